### src/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, constants and helpers for the Menger sponge voxel test.
// ----------------------------------------------------------------------------
package mss_pkg;

	// Q20.FRAC_BITS coordinates; unit_scale is Q4.28, so the scaling path
	// below assumes FRAC_BITS == 28 (no rescale shift).
	localparam int FRAC_BITS = 28;
	localparam int POS_W     = 16;
	localparam int DIFF_W    = POS_W + 1;
	localparam int DMAG_W    = POS_W;
	localparam int SCALE_W   = 32;
	localparam int PROD_W    = DMAG_W + SCALE_W;
	localparam int COORD_W   = 20 + FRAC_BITS;
	localparam int MAG_W     = COORD_W - 1;
	localparam int EXT_W     = COORD_W + 2;
	localparam int STEP_W    = 5;
	localparam int RHS_W     = 63;
	localparam int SMALL_W   = FRAC_BITS + 2;
	localparam int SQ_W      = 2 * SMALL_W;
	localparam int SUM_W     = SQ_W + 2;
	localparam int HALF_W    = 24;
	localparam int R_W       = 2 * MAG_W + 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [MAG_W-1:0]          mag_t;

	localparam mag_t VMAX = '1;
	localparam mag_t THREE_MAG = MAG_W'(64'd3 << FRAC_BITS);
	localparam coord_t ONE_C = coord_t'(64'd1 << FRAC_BITS);
	localparam logic signed [EXT_W-1:0] VMAX_E = $signed({3'b000, VMAX});
	localparam logic signed [EXT_W-1:0] TWO_E  = $signed(EXT_W'(64'd2 << FRAC_BITS));
	localparam logic [SUM_W-1:0] NINE_R2 = SUM_W'(128'd9 << (2 * FRAC_BITS));
	localparam logic [RHS_W-1:0] LIM62   = RHS_W'(64'd1 << 62);
	localparam logic [RHS_W-1:0] RHS_CAP = LIM62 / 63'd3;

	// register reset values
	localparam logic [POS_W-1:0]   RST_CENTER_X = 16'd4995;
	localparam logic [POS_W-1:0]   RST_CENTER_Y = 16'd5005;
	localparam logic [POS_W-1:0]   RST_CENTER_Z = 16'd4995;
	localparam logic [SCALE_W-1:0] RST_SCALE    = 32'd17896;
	localparam logic [STEP_W-1:0]  RST_MAX_IT   = 5'd13;
	localparam int                 DEF_MAX_ITER = 31;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X   = 3'd0,
		CFG_CENTER_Y   = 3'd1,
		CFG_CENTER_Z   = 3'd2,
		CFG_UNIT_SCALE = 3'd3,
		CFG_MAX_ITER   = 3'd4,
		CFG_INVERT     = 3'd5,
		CFG_SWAP_XY    = 3'd6,
		CFG_SWAP_YZ    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} in_t;

	typedef struct packed {
		logic              solid;
		logic              in_sponge;
		logic [STEP_W-1:0] steps_done;
	} out_t;

	// state of one point as it walks the fold chain
	typedef struct packed {
		coord_t             x;
		coord_t             y;
		coord_t             z;
		logic [STEP_W-1:0]  steps;
		logic [RHS_W-1:0]   rhs;
		logic               done;
	} iter_t;

	function automatic coord_t sat_ext(logic signed [EXT_W-1:0] v);
		coord_t r;
		if (v > VMAX_E)
			r = $signed({1'b0, VMAX});
		else if (v < -VMAX_E)
			r = -$signed({1'b0, VMAX});
		else
			r = v[COORD_W-1:0];
		return r;
	endfunction

	function automatic mag_t abs_mag(coord_t v);
		coord_t n;
		n = -v;
		return v[COORD_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

endpackage

### src/menger_sponge_voxel_test_unit.sv
// ----------------------------------------------------------------------------
// menger_sponge_voxel_test_unit
// Per-voxel Menger sponge membership test, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one voxel position per cycle and returns one result beat per
// position, in order. The pipe is built from three front
// stages (center offset, scale multiply, clamp and axis swap), three stages
// for each unrolled fold iteration (squares, r<9 test, fold/sort/affine),
// and three for the final estimate (partial products, square assembly,
// compare). Every stage advances together; a stalled output beat freezes the
// whole pipe and stalls the input. Configuration writes are taken any cycle
// (cfg_ready is tied high) and must only happen with the pipe empty.
module menger_sponge_voxel_test_unit #(
	parameter int MAX_ITER = mss_pkg::DEF_MAX_ITER
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  mss_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output mss_pkg::out_t                  out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mss_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mss_pkg::*;

	// configuration registers
	logic [POS_W-1:0]   center_x_q, center_y_q, center_z_q;
	logic [SCALE_W-1:0] scale_q;
	logic [STEP_W-1:0]  max_it_q;
	logic               invert_q, swap_xy_q, swap_yz_q;
	logic [STEP_W-1:0]  lim;

	// global advance: hold everything while the output beat is stalled
	logic en;

	// front stages
	logic signed [DIFF_W-1:0] diff_c [3];
	logic signed [POS_W-1:0]  pos_c [3];
	logic signed [POS_W-1:0]  ctr_c [3];
	logic                     v_s1, v_s2, v_s3;
	logic                     neg_s1 [3];
	logic [DMAG_W-1:0]        dmag_s1 [3];
	logic                     neg_s2 [3];
	logic [PROD_W-1:0]        prod_s2 [3];
	coord_t                   crd_c [3];
	coord_t                   sx, sy, sz, tmp;
	iter_t                    st_c, st_s3;

	// fold chain
	logic  chain_v  [MAX_ITER+1];
	iter_t chain_st [MAX_ITER+1];

	logic fin_valid;

	assign cfg_ready = 1'b1;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign lim = (int'(max_it_q) < MAX_ITER) ? max_it_q : STEP_W'(MAX_ITER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= RST_CENTER_X;
			center_y_q <= RST_CENTER_Y;
			center_z_q <= RST_CENTER_Z;
			scale_q    <= RST_SCALE;
			max_it_q   <= RST_MAX_IT;
			invert_q   <= 1'b1;
			swap_xy_q  <= 1'b0;
			swap_yz_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CENTER_X:   center_x_q <= cfg_data[POS_W-1:0];
				CFG_CENTER_Y:   center_y_q <= cfg_data[POS_W-1:0];
				CFG_CENTER_Z:   center_z_q <= cfg_data[POS_W-1:0];
				CFG_UNIT_SCALE: scale_q    <= cfg_data[SCALE_W-1:0];
				CFG_MAX_ITER:   max_it_q   <= cfg_data[STEP_W-1:0];
				CFG_INVERT:     invert_q   <= cfg_data[0];
				CFG_SWAP_XY:    swap_xy_q  <= cfg_data[0];
				CFG_SWAP_YZ:    swap_yz_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage 1: offset from center, split into sign and magnitude
	always_comb begin
		pos_c[0] = in_data.pos_x;
		pos_c[1] = in_data.pos_y;
		pos_c[2] = in_data.pos_z;
		ctr_c[0] = $signed(center_x_q);
		ctr_c[1] = $signed(center_y_q);
		ctr_c[2] = $signed(center_z_q);
		for (int a = 0; a < 3; a++)
			diff_c[a] = DIFF_W'(pos_c[a]) - DIFF_W'(ctr_c[a]);
	end

	// stage 3 input: saturate the Q20.28 product, restore sign, swap axes
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			crd_c[a] = (prod_s2[a] > PROD_W'(VMAX)) ? $signed({1'b0, VMAX})
			         : $signed({1'b0, prod_s2[a][MAG_W-1:0]});
			if (neg_s2[a])
				crd_c[a] = -crd_c[a];
		end
		tmp = '0;
		sx = crd_c[0];
		sy = crd_c[1];
		sz = crd_c[2];
		if (swap_xy_q) begin
			tmp = sx; sx = sy; sy = tmp;
		end
		if (swap_yz_q) begin
			tmp = sy; sy = sz; sz = tmp;
		end
		st_c.x     = sx;
		st_c.y     = sy;
		st_c.z     = sz;
		st_c.steps = '0;
		st_c.rhs   = RHS_W'(scale_q);
		st_c.done  = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				neg_s1[a]  <= diff_c[a][DIFF_W-1];
				dmag_s1[a] <= diff_c[a][DIFF_W-1] ? DMAG_W'(-diff_c[a])
				                                  : diff_c[a][DMAG_W-1:0];
				neg_s2[a]  <= neg_s1[a];
				prod_s2[a] <= PROD_W'(dmag_s1[a]) * PROD_W'(scale_q);
			end
			st_s3 <= st_c;
		end
	end

	assign chain_v[0]  = v_s3;
	assign chain_st[0] = st_s3;

	// unrolled fold iterations; an item that stops early rides through
	for (genvar k = 0; k < MAX_ITER; k++) begin : g_iter
		mss_iter #(
			.K (k)
		) u_iter (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.lim       (lim),
			.in_valid  (chain_v[k]),
			.in_st     (chain_st[k]),
			.out_valid (chain_v[k+1]),
			.out_st    (chain_st[k+1])
		);
	end

	mss_test u_test (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.inv       (invert_q),
		.in_valid  (chain_v[MAX_ITER]),
		.in_st     (chain_st[MAX_ITER]),
		.out_valid (fin_valid),
		.out_data  (out_data)
	);

	assign out_valid = fin_valid;

endmodule

### src/mss_iter.sv
// ----------------------------------------------------------------------------
// mss_iter
// One fold iteration: radius check, then abs/sort/scale of the point.
// ----------------------------------------------------------------------------
module mss_iter #(
	parameter int K = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [mss_pkg::STEP_W-1:0] lim,
	input  logic                       in_valid,
	input  mss_pkg::iter_t             in_st,
	output logic                       out_valid,
	output mss_pkg::iter_t             out_st
);
	import mss_pkg::*;

	// stage 1: magnitudes and squares (only exact when all below 4.0)
	mag_t              ax, ay, az;
	logic              small_c;
	logic [SQ_W-1:0]   sqx_c, sqy_c, sqz_c;

	logic              v_s1, small_s1;
	iter_t             st_s1;
	logic [SQ_W-1:0]   sqx_s1, sqy_s1, sqz_s1;

	// stage 2: r < 9 and loop bound
	logic [SUM_W-1:0]  sum_c;
	logic              act_c;
	logic              v_s2, act_s2;
	iter_t             st_s2;

	// stage 3: fold
	mag_t              ma, mb, mc, mt, ta, tb, tc;
	logic [EXT_W-1:0]  a3, b3, c3;
	coord_t            nx, ny, nz3, nz;
	iter_t             nxt_c;
	logic              v_s3;
	iter_t             st_s3;

	always_comb begin
		ax = abs_mag(in_st.x);
		ay = abs_mag(in_st.y);
		az = abs_mag(in_st.z);
		small_c = (ax < THREE_MAG) && (ay < THREE_MAG) && (az < THREE_MAG);
		sqx_c = ax[SMALL_W-1:0] * ax[SMALL_W-1:0];
		sqy_c = ay[SMALL_W-1:0] * ay[SMALL_W-1:0];
		sqz_c = az[SMALL_W-1:0] * az[SMALL_W-1:0];
	end

	always_comb begin
		sum_c = SUM_W'(sqx_s1) + SUM_W'(sqy_s1) + SUM_W'(sqz_s1);
		act_c = small_s1 && !st_s1.done && (K < int'(lim)) && (sum_c < NINE_R2);
	end

	always_comb begin
		ma = abs_mag(st_s2.x);
		mb = abs_mag(st_s2.y);
		mc = abs_mag(st_s2.z);
		// descending sort: x/y, x/z, then y/z
		mt = '0;
		ta = ma; tb = mb; tc = mc;
		if (ta < tb) begin
			mt = ta; ta = tb; tb = mt;
		end
		if (ta < tc) begin
			mt = ta; ta = tc; tc = mt;
		end
		if (tb < tc) begin
			mt = tb; tb = tc; tc = mt;
		end
		a3 = {3'b000, ta} + {2'b00, ta, 1'b0};
		b3 = {3'b000, tb} + {2'b00, tb, 1'b0};
		c3 = {3'b000, tc} + {2'b00, tc, 1'b0};
		nx  = sat_ext($signed(a3) - TWO_E);
		ny  = sat_ext($signed(b3) - TWO_E);
		nz3 = sat_ext($signed(c3));
		nz  = (nz3 > ONE_C) ? sat_ext(EXT_W'(nz3) - TWO_E) : nz3;

		nxt_c = st_s2;
		if (act_s2) begin
			nxt_c.x     = nx;
			nxt_c.y     = ny;
			nxt_c.z     = nz;
			nxt_c.steps = st_s2.steps + STEP_W'(1);
			nxt_c.rhs   = (st_s2.rhs >= RHS_CAP) ? LIM62 :
			              st_s2.rhs + {st_s2.rhs[RHS_W-2:0], 1'b0};
		end else begin
			nxt_c.done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1    <= in_st;
			small_s1 <= small_c;
			sqx_s1   <= sqx_c;
			sqy_s1   <= sqy_c;
			sqz_s1   <= sqz_c;
			st_s2    <= st_s1;
			act_s2   <= act_c;
			st_s3    <= nxt_c;
		end
	end

	assign out_valid = v_s3;
	assign out_st    = st_s3;

endmodule

### src/mss_test.sv
// ----------------------------------------------------------------------------
// mss_test
// Final estimate: r < (scale * 3^i)^2, with partial-product squares.
// ----------------------------------------------------------------------------
module mss_test (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           inv,
	input  logic           in_valid,
	input  mss_pkg::iter_t in_st,
	output logic           out_valid,
	output mss_pkg::out_t  out_data
);
	import mss_pkg::*;

	localparam int HI_W = MAG_W - HALF_W;

	mag_t                     m_c [3];
	logic                     v_s1, v_s2, v_s3;
	logic [2*HI_W-1:0]        hh_s1 [3];
	logic [HI_W+HALF_W-1:0]   hl_s1 [3];
	logic [2*HALF_W-1:0]      ll_s1 [3];
	logic [2*HALF_W-1:0]      rhh_s1, rhl_s1, rll_s1;
	logic                     big_s1, big_s2;
	logic [STEP_W-1:0]        steps_s1, steps_s2;
	logic [R_W-1:0]           sq_s2 [3];
	logic [R_W-1:0]           rhs2_s2;
	logic [R_W-1:0]           r_c;
	logic                     inside_c;
	out_t                     out_s3;

	always_comb begin
		m_c[0] = abs_mag(in_st.x);
		m_c[1] = abs_mag(in_st.y);
		m_c[2] = abs_mag(in_st.z);
		r_c = sq_s2[0] + sq_s2[1] + sq_s2[2];
		inside_c = big_s2 || (r_c < rhs2_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				hh_s1[a] <= m_c[a][MAG_W-1:HALF_W] * m_c[a][MAG_W-1:HALF_W];
				hl_s1[a] <= m_c[a][MAG_W-1:HALF_W] * m_c[a][HALF_W-1:0];
				ll_s1[a] <= m_c[a][HALF_W-1:0] * m_c[a][HALF_W-1:0];
				sq_s2[a] <= (R_W'(hh_s1[a]) << (2 * HALF_W))
				          + (R_W'(hl_s1[a]) << (HALF_W + 1))
				          + R_W'(ll_s1[a]);
			end
			// sqrt(r) < rhs is r < rhs^2; rhs >= 2^48 always wins
			big_s1   <= |in_st.rhs[RHS_W-1:2*HALF_W];
			rhh_s1   <= in_st.rhs[2*HALF_W-1:HALF_W] * in_st.rhs[2*HALF_W-1:HALF_W];
			rhl_s1   <= in_st.rhs[2*HALF_W-1:HALF_W] * in_st.rhs[HALF_W-1:0];
			rll_s1   <= in_st.rhs[HALF_W-1:0] * in_st.rhs[HALF_W-1:0];
			steps_s1 <= in_st.steps;
			rhs2_s2  <= (R_W'(rhh_s1) << (2 * HALF_W)) + (R_W'(rhl_s1) << (HALF_W + 1))
			          + R_W'(rll_s1);
			big_s2   <= big_s1;
			steps_s2 <= steps_s1;
			out_s3.in_sponge  <= inside_c;
			out_s3.solid      <= inside_c ^ inv;
			out_s3.steps_done <= steps_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = out_s3;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the Menger sponge voxel test unit against a bit-exact predictor of
// the fixed-point fold iteration, under random gaps and stalls on both sides.
// ----------------------------------------------------------------------------

import mss_pkg::*;

// Holds the register image, predicts each voxel verdict and checks results
// in order.
class voxel_scoreboard;
	logic signed [15:0] ctr_x, ctr_y, ctr_z;
	logic [31:0]        unit_scale;
	logic [4:0]         iter_bound;
	logic               invert, swap_xy, swap_yz;
	out_t               verdicts[$];
	int                 errors;

	localparam longint COORD_MAX = (longint'(1) << 47) - 1;
	localparam logic [63:0] RHS_LIM = 64'h4000_0000_0000_0000;

	function new();
		ctr_x = 16'sd4995;
		ctr_y = 16'sd5005;
		ctr_z = 16'sd4995;
		unit_scale = 32'd17896;
		iter_bound = 5'd13;
		invert = 1'b1;
		swap_xy = 1'b0;
		swap_yz = 1'b1;
		errors = 0;
	endfunction

	function void write_reg(cfg_idx_t idx, logic [31:0] val);
		case (idx)
			CFG_CENTER_X:   ctr_x = val[15:0];
			CFG_CENTER_Y:   ctr_y = val[15:0];
			CFG_CENTER_Z:   ctr_z = val[15:0];
			CFG_UNIT_SCALE: unit_scale = val;
			CFG_MAX_ITER:   iter_bound = val[4:0];
			CFG_INVERT:     invert = val[0];
			CFG_SWAP_XY:    swap_xy = val[0];
			CFG_SWAP_YZ:    swap_yz = val[0];
			default: ;
		endcase
	endfunction

	function longint clamp(longint v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < -COORD_MAX)
			return -COORD_MAX;
		return v;
	endfunction

	// offset times scale on the magnitude, clamped, sign put back
	function longint scale_offset(int d);
		longint unsigned m;
		m = longint'(d < 0 ? -d : d) * longint'({32'd0, unit_scale});
		if (m > COORD_MAX)
			m = COORD_MAX;
		return d < 0 ? -longint'(m) : longint'(m);
	endfunction

	function logic [127:0] square(longint v);
		logic [127:0] a;
		a = 128'(v < 0 ? -v : v);
		return a * a;
	endfunction

	function out_t sponge_verdict(in_t v);
		longint x, y, z, t;
		logic [127:0] r2, root, cand;
		logic [63:0] rhs;
		int steps;
		logic in_hit;
		out_t res;
		x = scale_offset(int'(v.pos_x) - int'(ctr_x));
		y = scale_offset(int'(v.pos_y) - int'(ctr_y));
		z = scale_offset(int'(v.pos_z) - int'(ctr_z));
		if (swap_xy) begin
			t = x; x = y; y = t;
		end
		if (swap_yz) begin
			t = y; y = z; z = t;
		end
		r2 = square(x) + square(y) + square(z);
		steps = 0;
		while (steps < iter_bound && r2 < (128'd9 << 56)) begin
			x = clamp(x < 0 ? -x : x);
			y = clamp(y < 0 ? -y : y);
			z = clamp(z < 0 ? -z : z);
			if (x < y) begin
				t = x; x = y; y = t;
			end
			if (x < z) begin
				t = x; x = z; z = t;
			end
			if (y < z) begin
				t = y; y = z; z = t;
			end
			x = clamp(3 * x - (longint'(2) << 28));
			y = clamp(3 * y - (longint'(2) << 28));
			z = clamp(3 * z);
			if (z > (longint'(1) << 28))
				z = clamp(z - (longint'(2) << 28));
			r2 = square(x) + square(y) + square(z);
			steps++;
		end
		// integer square root, then compare with scale * 3^steps
		root = '0;
		for (int b = 62; b >= 0; b--) begin
			cand = root | (128'd1 << b);
			if (!(r2 < cand * cand))
				root = cand;
		end
		rhs = {32'd0, unit_scale};
		for (int k = 0; k < steps; k++)
			rhs = (rhs >= RHS_LIM / 3) ? RHS_LIM : rhs * 3;
		in_hit = root < 128'(rhs);
		res.solid = in_hit ^ invert;
		res.in_sponge = in_hit;
		res.steps_done = steps[4:0];
		return res;
	endfunction

	function void note_voxel(in_t v);
		verdicts.push_back(sponge_verdict(v));
	endfunction

	function void check_result(out_t got);
		out_t exp_v;
		if (verdicts.size() == 0) begin
			$display("%0t: unexpected result beat %p", $time, got);
			errors++;
			return;
		end
		exp_v = verdicts.pop_front();
		if (got.solid !== exp_v.solid) begin
			$display("%0t: solid expected %b got %b", $time, exp_v.solid, got.solid);
			errors++;
		end
		if (got.in_sponge !== exp_v.in_sponge) begin
			$display("%0t: in_sponge expected %b got %b", $time,
				exp_v.in_sponge, got.in_sponge);
			errors++;
		end
		if (got.steps_done !== exp_v.steps_done) begin
			$display("%0t: steps_done expected %0d got %0d", $time,
				exp_v.steps_done, got.steps_done);
			errors++;
		end
	endfunction
endclass

module testbench;
	// pipe depth: 3 front + 3 per fold + 3 back
	localparam int PIPE_DEPTH = 3 + 3 * DEF_MAX_ITER + 3;
	localparam int PHASE_ITEMS = 166;

	logic clk;
	logic arst_n;
	logic in_valid, in_stall;
	in_t  in_data;
	logic out_valid, out_stall;
	out_t out_data;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	voxel_scoreboard sb;
	bit hold_req;      // sender asks receiver for one long hold-off
	bit calm_sender;   // phase runs with no input gaps
	int span;          // voxels per fractal unit in the current phase

	menger_sponge_voxel_test_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// hard limit on the run
	initial begin
		#6_000_000;
		$display("tb: failure");
		$finish;
	end

	// every accepted result beat goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// receiver: random stalls, quiet stretches, and one long hold-off on request
	initial begin : receiver
		int stall_left, free_left, pick;
		stall_left = 0;
		free_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_stall <= 1'b1;
				// count the hold in cycles so the pipe fills and stalls the input
				repeat (3 * PIPE_DEPTH) @(negedge clk);
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (free_left > 0) begin
				free_left--;
				out_stall <= 1'b0;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					out_stall <= 1'b0;
				else if (pick < 88) begin
					out_stall <= 1'b1;
					stall_left = $urandom_range(0, 2);
				end else if (pick < 94) begin
					out_stall <= 1'b1;
					stall_left = $urandom_range(15, 50);
				end else begin
					out_stall <= 1'b0;
					free_left = $urandom_range(40, 200);
				end
			end
		end
	end

	// offer one beat after a gap, hold it until accepted
	task automatic send_voxel(in_t v);
		int gap, pick;
		pick = $urandom_range(0, 99);
		if (calm_sender || pick < 50)
			gap = 0;
		else if (pick < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 50);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
			in_data <= in_t'(48'({$urandom, $urandom}));
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= v;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_voxel(v);
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// wait out the pipe: all verdicts back, then more than a pipe depth of idle clocks
	task automatic drain_pipe();
		drop_valid();
		while (sb.verdicts.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data <= $urandom;
	endtask

	task automatic load_config(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
			logic [31:0] scl, logic [4:0] iters, bit inv, bit sxy, bit syz);
		write_reg(CFG_CENTER_X, {16'd0, cx});
		write_reg(CFG_CENTER_Y, {16'd0, cy});
		write_reg(CFG_CENTER_Z, {16'd0, cz});
		write_reg(CFG_UNIT_SCALE, scl);
		write_reg(CFG_MAX_ITER, {27'd0, iters});
		write_reg(CFG_INVERT, {31'd0, inv});
		write_reg(CFG_SWAP_XY, {31'd0, sxy});
		write_reg(CFG_SWAP_YZ, {31'd0, syz});
	endtask

	function automatic logic [15:0] near_axis(logic signed [15:0] c);
		return 16'(int'(c) + $urandom_range(0, 2 * span) - span);
	endfunction

	// mostly positions around the center within one fractal unit per axis
	function automatic in_t draw_voxel();
		in_t v;
		if ($urandom_range(0, 9) < 7) begin
			v.pos_x = near_axis(sb.ctr_x);
			v.pos_y = near_axis(sb.ctr_y);
			v.pos_z = near_axis(sb.ctr_z);
		end else
			v = in_t'(48'({$urandom, $urandom}));
		return v;
	endfunction

	function automatic in_t voxel(int x, int y, int z);
		in_t v;
		v.pos_x = 16'(x);
		v.pos_y = 16'(y);
		v.pos_z = 16'(z);
		return v;
	endfunction

	task automatic random_phase(int count);
		for (int n = 0; n < count; n++) begin
			send_voxel(draw_voxel());
			if (n == count / 2 && $urandom_range(0, 2) == 0) begin
				drop_valid();
				while (sb.verdicts.size() != 0)
					@(posedge clk);
			end
		end
	endtask

	initial begin : stimulus
		int c0, c1, c2;
		sb = new();
		hold_req = 0;
		calm_sender = 0;
		span = 15000;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CENTER_X;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, reset settings: center point, extremes, axis corners
		send_voxel(voxel(4995, 5005, 4995));
		send_voxel(voxel(-32768, -32768, -32768));
		send_voxel(voxel(32767, 32767, 32767));
		send_voxel(voxel(-32768, 32767, -32768));
		send_voxel(voxel(32767, -32768, 0));
		send_voxel(voxel(0, 0, 0));
		send_voxel(voxel(-1, -1, -1));
		send_voxel(voxel(4995 + 15000, 5005, 4995));
		send_voxel(voxel(4995, 5005 + 5000, 4995 - 5000));
		send_voxel(voxel(4995 + 14000, 5005 + 14000, 4995 + 14000));
		drain_pipe();

		// saturated scale, widest iteration bound, x and y centers at the extremes
		load_config(16'h8000, 16'h7fff, 16'h0000, 32'hffff_ffff, 5'd31, 1'b0, 1'b1, 1'b0);
		send_voxel(voxel(32767, -32768, 0));
		send_voxel(voxel(-32768, 32767, 0));
		send_voxel(voxel(-32768, 32767, 1));
		send_voxel(voxel(32767, 32767, -32768));
		drain_pipe();

		// zero scale maps everything to the origin; zero iteration bound
		load_config(16'h7fff, 16'h8000, 16'h7fff, 32'd0, 5'd0, 1'b1, 1'b0, 1'b0);
		send_voxel(voxel(32767, -32768, 32767));
		send_voxel(voxel(-32768, 32767, -32768));
		send_voxel(voxel(123, -456, 789));
		drain_pipe();

		// one voxel per unit: folds hit saturation and the r >= 9 exit
		load_config(16'h0000, 16'h0000, 16'h0000, 32'h1000_0000, 5'd31, 1'b0, 1'b1, 1'b1);
		span = 4;
		send_voxel(voxel(0, 0, 0));
		send_voxel(voxel(1, 1, 1));
		send_voxel(voxel(2, 0, 0));
		send_voxel(voxel(-3, 1, -1));
		send_voxel(voxel(1, 0, -1));
		random_phase(PHASE_ITEMS - 5);
		drain_pipe();

		// random settings, each phase full rate or gapped
		for (int p = 0; p < 7; p++) begin
			span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
				: $urandom_range(20, 4000);
			c0 = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000) - 10000;
			c1 = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000) - 10000;
			c2 = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000) - 10000;
			load_config(16'(c0), 16'(c1), 16'(c2),
				($urandom_range(0, 9) == 0) ? $urandom
					: (32'h1000_0000 / span + $urandom_range(0, 3)),
				5'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
					: $urandom_range(6, 31)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			calm_sender = (p % 3 == 1);
			// long receiver hold-off while the sender keeps offering
			if (p == 2)
				hold_req = 1;
			random_phase(PHASE_ITEMS);
			drain_pipe();
		end

		calm_sender = 0;
		drop_valid();
		while (sb.verdicts.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 20) @(posedge clk);
		if (sb.errors == 0 && sb.verdicts.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
